FILE: rtl/cspu_pkg.sv
`timescale 1ns / 1ps

package cspu_pkg;

	localparam int PAYLOAD_BYTES_DEF = 8;

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_EXTRACT = 2'd1;
	localparam logic [1:0] KIND_INSERT  = 2'd2;

	localparam logic [6:0] MAX_SIGNAL_BITS = 7'd64;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOAD = 5'b00010,
		S_WALK = 5'b00100,
		S_PACK = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	// control from the sequencer to the bit walker
	typedef struct packed {
		logic       init;
		logic       step;
		logic       big;
		logic [5:0] start_bit;
		logic [6:0] bits;
	} walk_ctl_t;

	// current walk position and the byte a wrap would move to
	typedef struct packed {
		logic signed [5:0] byte_idx;
		logic signed [5:0] next_byte;
		logic [2:0]        bit_pos;
	} walk_pos_t;

endpackage

FILE: rtl/cspu_if.sv
`timescale 1ns / 1ps

interface cspu_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [63:0]        payload_data;
	logic [3:0]         payload_length;
	logic [5:0]         start_bit;
	logic [6:0]         signal_bits;
	logic               big_endian;
	logic               is_signed;
	logic signed [63:0] insert_value;

	modport source (
		output valid, kind, payload_data, payload_length, start_bit, signal_bits,
		       big_endian, is_signed, insert_value,
		input  ready
	);
	modport sink (
		input  valid, kind, payload_data, payload_length, start_bit, signal_bits,
		       big_endian, is_signed, insert_value,
		output ready
	);
endinterface

interface cspu_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] extracted_value;
	logic [63:0]        payload_out;
	logic [3:0]         length_out;

	modport source (
		output valid, extracted_value, payload_out, length_out,
		input  ready
	);
	modport sink (
		input  valid, extracted_value, payload_out, length_out,
		output ready
	);
endinterface

FILE: rtl/cspu_bit_walker.sv
`timescale 1ns / 1ps

module cspu_bit_walker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cspu_pkg::walk_ctl_t   ctl,
	output cspu_pkg::walk_pos_t   pos
);
	import cspu_pkg::*;

	logic signed [5:0] byte_q;
	logic [2:0]        bit_q;
	logic              big_q;
	logic [6:0]        msb_lin;
	logic signed [5:0] next_byte;

	// motorola: count forward in msb-first linear order, then map back to dbc numbering
	assign msb_lin = {1'b0, ctl.start_bit[5:3], ~ctl.start_bit[2:0]} + ctl.bits - 7'd1;
	assign next_byte = big_q ? (byte_q - 6'sd1) : (byte_q + 6'sd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			bit_q  <= '0;
			big_q  <= 1'b0;
		end else if (ctl.init) begin
			big_q <= ctl.big;
			if (ctl.big && (ctl.bits != 7'd0)) begin
				byte_q <= {2'b00, msb_lin[6:3]};
				bit_q  <= ~msb_lin[2:0];
			end else begin
				byte_q <= {3'b000, ctl.start_bit[5:3]};
				bit_q  <= ctl.start_bit[2:0];
			end
		end else if (ctl.step) begin
			if (bit_q == 3'd7) begin
				bit_q  <= 3'd0;
				byte_q <= next_byte;
			end else begin
				bit_q <= bit_q + 3'd1;
			end
		end
	end

	assign pos.byte_idx  = byte_q;
	assign pos.next_byte = next_byte;
	assign pos.bit_pos   = bit_q;

endmodule

FILE: rtl/can_signal_pack_unpack_unit.sv
`timescale 1ns / 1ps

// CAN signal pack/unpack unit. Holds one payload of up to PAYLOAD_BYTES bytes,
// byte 0 the most significant byte of the payload word.
// cmd channel: one transfer per item (load, extract, insert; kind 3 is a no-op).
// res channel: one transfer per item with the extracted value, the payload word
// and the length after the item.
// Steps from the cmd transfer up to res.valid:
//   load     one byte per cycle in, then one byte per cycle packed out
//   extract  one signal bit per cycle over the 64-step bit walk, insert the same,
//            then the byte-serial packing pass
//   kind 3   the byte-serial packing pass only
// cmd.ready is high only while no item is in work, so a new item is taken only
// once the last is through. The result sits in an output register: the next item is
// accepted while it waits, and that item holds before its own result until
// res is taken.
// Reset clears the payload to all zero bytes and the length to zero; no
// clearing pass is needed.
module can_signal_pack_unpack_unit #(
	parameter int PAYLOAD_BYTES = cspu_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	cspu_in_if.sink           cmd,
	cspu_out_if.source        res
);
	import cspu_pkg::*;

	localparam int         IW        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam logic [5:0] LAST_BYTE = 6'(PAYLOAD_BYTES - 1);
	localparam logic [3:0] MAX_LEN   = 4'(PAYLOAD_BYTES);

	state_t       state_q;
	logic [1:0]   kind_q;
	logic [63:0]  sr_q;
	logic [63:0]  word_q;
	logic [6:0]   bits_q;
	logic         sgn_q;
	logic         last_q;
	logic         go_q;
	logic [5:0]   cnt_q;
	logic [3:0]   len_q;
	logic [3:0]   new_len_q;
	logic [7:0]   bytes_q [PAYLOAD_BYTES];
	logic         res_valid_q;
	logic [63:0]  out_ext_q;
	logic [63:0]  out_word_q;
	logic [3:0]   out_len_q;

	logic         accept;
	logic [6:0]   sat_bits;
	logic [3:0]   load_len;
	logic         active;
	logic         cur_in;
	logic         nxt_in;
	logic         cnt_in_len;
	logic [IW-1:0] rd_idx;
	logic [7:0]   rd_byte;
	logic         rd_bit;
	logic         fill;
	logic         set_bit;
	logic         out_free;
	walk_ctl_t    wctl;
	walk_pos_t    wpos;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);

	assign sat_bits = (cmd.signal_bits > MAX_SIGNAL_BITS) ? MAX_SIGNAL_BITS : cmd.signal_bits;
	assign load_len = (cmd.payload_length > MAX_LEN) ? MAX_LEN : cmd.payload_length;

	assign active = ({1'b0, cnt_q} < bits_q);

	assign cur_in = !wpos.byte_idx[5] && (wpos.byte_idx[4:0] < {1'b0, len_q});
	assign nxt_in = !wpos.next_byte[5] && (wpos.next_byte[4:0] < {1'b0, len_q});

	// byte counter against the length in use: the new one during load
	assign cnt_in_len = (state_q == S_LOAD) ? (cnt_q < {2'b00, new_len_q})
	                                        : (cnt_q < {2'b00, len_q});

	assign rd_idx  = (state_q == S_WALK) ? wpos.byte_idx[IW-1:0] : cnt_q[IW-1:0];
	assign rd_byte = bytes_q[rd_idx];
	assign rd_bit  = cur_in && rd_byte[wpos.bit_pos];

	// past the signal, shift in sign fill (or zero) so the value ends right-aligned
	assign fill = active ? rd_bit : (sgn_q && last_q);

	assign set_bit = (state_q == S_WALK) && (kind_q == KIND_INSERT) && active &&
	                 go_q && cur_in && sr_q[0];

	assign out_free = !res_valid_q || res.ready;

	assign wctl.init      = accept;
	assign wctl.step      = (state_q == S_WALK) && active;
	assign wctl.big       = cmd.big_endian;
	assign wctl.start_bit = cmd.start_bit;
	assign wctl.bits      = sat_bits;

	cspu_bit_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.pos    (wpos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= KIND_LOAD;
			cnt_q       <= '0;
			len_q       <= '0;
			new_len_q   <= '0;
			bits_q      <= '0;
			sgn_q       <= 1'b0;
			last_q      <= 1'b0;
			go_q        <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q    <= cmd.kind;
						bits_q    <= sat_bits;
						sgn_q     <= cmd.is_signed;
						new_len_q <= load_len;
						last_q    <= 1'b0;
						go_q      <= 1'b1;
						if (cmd.kind == KIND_LOAD) begin
							cnt_q   <= LAST_BYTE;
							state_q <= S_LOAD;
						end else if (cmd.kind == KIND_EXTRACT || cmd.kind == KIND_INSERT) begin
							cnt_q   <= '0;
							state_q <= S_WALK;
						end else begin
							cnt_q   <= '0;
							state_q <= S_PACK;
						end
					end
				end
				S_LOAD: begin
					if (cnt_q == 6'd0) begin
						len_q   <= new_len_q;
						state_q <= S_PACK;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_WALK: begin
					if (active)
						last_q <= rd_bit;
					// insert stops for good once a wrap lands outside the payload
					if (kind_q == KIND_INSERT && active && wpos.bit_pos == 3'd7 && !nxt_in)
						go_q <= 1'b0;
					if (cnt_q == 6'd63) begin
						cnt_q   <= '0;
						state_q <= S_PACK;
						if (kind_q == KIND_INSERT && len_q == 4'd0)
							len_q <= 4'd1;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_PACK: begin
					if (cnt_q == LAST_BYTE)
						state_q <= S_OUT;
					else
						cnt_q <= cnt_q + 6'd1;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (state_q == S_OUT && out_free)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	// shift register: load bytes leave at the bottom, insert bits leave at the
	// bottom, extract bits enter at the top
	always_ff @(posedge clk) begin
		if (accept) begin
			sr_q <= (cmd.kind == KIND_INSERT) ? cmd.insert_value : cmd.payload_data;
		end else if (state_q == S_LOAD) begin
			if (cnt_in_len)
				sr_q <= {8'h00, sr_q[63:8]};
		end else if (state_q == S_WALK) begin
			sr_q <= {fill, sr_q[63:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (accept || state_q == S_LOAD || state_q == S_WALK)
			word_q <= '0;
		else if (state_q == S_PACK && cnt_in_len)
			word_q <= {word_q[55:0], rd_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAYLOAD_BYTES; i++)
				bytes_q[i] <= 8'h00;
		end else if (state_q == S_LOAD) begin
			bytes_q[cnt_q[IW-1:0]] <= cnt_in_len ? sr_q[7:0] : 8'h00;
		end else if (set_bit) begin
			bytes_q[wpos.byte_idx[IW-1:0]][wpos.bit_pos] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_ext_q  <= (kind_q == KIND_EXTRACT) ? sr_q : 64'd0;
			out_word_q <= word_q;
			out_len_q  <= len_q;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.extracted_value = out_ext_q;
	assign res.payload_out     = out_word_q;
	assign res.length_out      = out_len_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> len_q <= MAX_LEN)
		else $error("payload length above capacity");

	a_go_only_in_insert: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(go_q) |-> $past(state_q == S_WALK && kind_q == KIND_INSERT))
		else $error("insert stop flag dropped outside an insert walk");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && res.valid && !res.ready) |=> state_q == S_OUT)
		else $error("result register overwritten while pending");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import cspu_pkg::*;

	localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam int RANDOM_PER_PHASE = 182;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [1:0]         kind;
		logic [63:0]        data;
		logic [3:0]         plen;
		logic [5:0]         start;
		logic [6:0]         bits;
		logic               big;
		logic               sgn;
		logic signed [63:0] value;
	} cmd_item_t;

	typedef struct {
		logic signed [63:0] ext;
		logic [63:0]        word;
		logic [3:0]         len;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n;

	cspu_in_if  cmd ();
	cspu_out_if res ();

	can_signal_pack_unpack_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	always #2 clk = ~clk;

	// shadow copy of the payload held by the block
	logic [7:0] shadow_bytes [PAYLOAD_BYTES];
	int         shadow_len;

	cmd_item_t cmd_items_q[$];
	frame_t    frame_results_q[$];
	cmd_item_t drv_item;
	frame_t    exp_frame;
	frame_t    pred_frame;
	int        items_sent;
	int        items_taken;
	int        errors;
	int        send_idle_pct;
	int        recv_stall_pct;
	logic      cmd_took = 1'b0;
	logic      hold_req = 1'b0;
	logic      hold_done = 1'b0;
	int        hold_left = 0;

	function automatic logic [7:0] shadow_read(int idx);
		if (idx >= 0 && idx < shadow_len && idx < PAYLOAD_BYTES)
			return shadow_bytes[idx];
		return 8'h00;
	endfunction

	function automatic void shadow_write(int idx, logic [7:0] v);
		if (idx >= 0 && idx < shadow_len && idx < PAYLOAD_BYTES)
			shadow_bytes[idx] = v;
	endfunction

	// motorola: count back from the start bit to find where the lsb sits
	function automatic int signal_lsb(int start, int nbits, logic big);
		int pos;
		int bidx;
		int i;
		if (!big)
			return start;
		pos = start % 8;
		bidx = start / 8;
		for (i = 1; i < nbits; i++) begin
			pos--;
			if (pos < 0) begin
				pos = 7;
				bidx++;
			end
		end
		return bidx * 8 + pos;
	endfunction

	function automatic logic [63:0] extract_raw(int start, int nbits, logic big, logic sgn);
		int         bidx;
		int         lsb;
		int         i;
		logic [7:0] mask;
		logic [7:0] cur;
		logic [63:0] val;
		logic       last;
		lsb = signal_lsb(start, nbits, big);
		bidx = lsb / 8;
		mask = 8'h01 << (lsb % 8);
		cur = shadow_read(bidx);
		val = '0;
		last = 1'b0;
		for (i = 0; i < nbits; i++) begin
			last = (cur & mask) != 8'h00;
			if (last)
				val[i] = 1'b1;
			if (mask == 8'h80) begin
				mask = 8'h01;
				bidx = big ? bidx - 1 : bidx + 1;
				cur = shadow_read(bidx);
			end else begin
				mask = mask << 1;
			end
		end
		if (sgn && last && nbits < 64)
			val = val | ({64{1'b1}} << nbits);
		return val;
	endfunction

	function automatic void insert_raw(int start, int nbits, logic big, logic [63:0] v);
		int         bidx;
		int         lsb;
		int         i;
		logic [7:0] mask;
		logic [7:0] cur;
		logic       stopped;
		lsb = signal_lsb(start, nbits, big);
		bidx = lsb / 8;
		mask = 8'h01 << (lsb % 8);
		cur = shadow_read(bidx);
		stopped = 1'b0;
		for (i = 0; i < nbits && !stopped; i++) begin
			if (v[i])
				cur = cur | mask;
			if (mask == 8'h80) begin
				shadow_write(bidx, cur);
				mask = 8'h01;
				bidx = big ? bidx - 1 : bidx + 1;
				// stepping past either end of the payload ends the insert
				if (bidx < 0 || bidx >= shadow_len)
					stopped = 1'b1;
				else
					cur = shadow_read(bidx);
			end else begin
				mask = mask << 1;
			end
		end
		if (!stopped)
			shadow_write(bidx, cur);
		if (shadow_len == 0)
			shadow_len = 1;
	endfunction

	function automatic frame_t pack_unpack_step(cmd_item_t it);
		frame_t r;
		int     nbits;
		int     plen;
		int     k;
		nbits = (it.bits > 7'd64) ? 64 : int'(it.bits);
		r.ext = '0;
		case (it.kind)
			KIND_LOAD: begin
				plen = (it.plen > 4'(PAYLOAD_BYTES)) ? PAYLOAD_BYTES : int'(it.plen);
				for (k = 0; k < PAYLOAD_BYTES; k++)
					shadow_bytes[k] = 8'h00;
				for (k = 0; k < plen; k++)
					shadow_bytes[k] = 8'(it.data >> (8 * (plen - 1 - k)));
				shadow_len = plen;
			end
			KIND_EXTRACT: r.ext = extract_raw(int'(it.start), nbits, it.big, it.sgn);
			KIND_INSERT: insert_raw(int'(it.start), nbits, it.big, it.value);
			default: ;
		endcase
		r.word = '0;
		for (k = 0; k < shadow_len && k < PAYLOAD_BYTES; k++)
			r.word = (r.word << 8) | 64'(shadow_bytes[k]);
		r.len = 4'(shadow_len);
		return r;
	endfunction

	function automatic void push_cmd(logic [1:0] kind, logic [63:0] data, logic [3:0] plen,
			logic [5:0] start, logic [6:0] bits, logic big, logic sgn,
			logic signed [63:0] value);
		cmd_item_t it;
		it.kind = kind;
		it.data = data;
		it.plen = plen;
		it.start = start;
		it.bits = bits;
		it.big = big;
		it.sgn = sgn;
		it.value = value;
		cmd_items_q = {cmd_items_q, it};
		items_sent++;
	endfunction

	// mostly short signals placed inside the bytes loaded so far
	function automatic cmd_item_t random_item(int cur_len);
		cmd_item_t it;
		int        sel;
		it.data = {$urandom, $urandom};
		it.value = {$urandom, $urandom};
		it.big = 1'($urandom_range(1));
		it.sgn = 1'($urandom_range(1));
		it.plen = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
		sel = $urandom_range(99);
		it.kind = (sel < 12) ? KIND_LOAD : (sel < 54) ? KIND_EXTRACT :
			(sel < 96) ? KIND_INSERT : KIND_NOP;
		sel = $urandom_range(9);
		it.bits = (sel < 6) ? 7'($urandom_range(24, 1)) :
			(sel < 9) ? 7'($urandom_range(64, 25)) : 7'($urandom_range(127));
		if ($urandom_range(3) != 0 && cur_len > 0)
			it.start = 6'($urandom_range(8 * cur_len - 1));
		else
			it.start = 6'($urandom_range(63));
		return it;
	endfunction

	// command driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd.valid || cmd_took) begin
				if (cmd_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_item = cmd_items_q.pop_front();
					cmd.valid <= 1'b1;
					cmd.kind <= drv_item.kind;
					cmd.payload_data <= drv_item.data;
					cmd.payload_length <= drv_item.plen;
					cmd.start_bit <= drv_item.start;
					cmd.signal_bits <= drv_item.bits;
					cmd.big_endian <= drv_item.big;
					cmd.is_signed <= drv_item.sgn;
					cmd.insert_value <= drv_item.value;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// result ready driver, with one long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_done) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// monitor: check each result transfer, then predict each command transfer
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_took <= cmd.valid && cmd.ready;
			if (res.valid && res.ready) begin
				if (frame_results_q.size() == 0) begin
					$error("result transfer with no result expected");
					errors++;
				end else begin
					exp_frame = frame_results_q.pop_front();
					if (res.extracted_value !== exp_frame.ext) begin
						$error("extracted_value: expected %h, got %h",
							exp_frame.ext, res.extracted_value);
						errors++;
					end
					if (res.payload_out !== exp_frame.word) begin
						$error("payload_out: expected %h, got %h",
							exp_frame.word, res.payload_out);
						errors++;
					end
					if (res.length_out !== exp_frame.len) begin
						$error("length_out: expected %0d, got %0d",
							exp_frame.len, res.length_out);
						errors++;
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				pred_frame = pack_unpack_step('{cmd.kind, cmd.payload_data,
					cmd.payload_length, cmd.start_bit, cmd.signal_bits, cmd.big_endian,
					cmd.is_signed, cmd.insert_value});
				frame_results_q = {frame_results_q, pred_frame};
				items_taken++;
			end
		end
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int        ph;
		int        n;
		int        gen_len;
		cmd_item_t it;
		items_sent = 0;
		items_taken = 0;
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		shadow_len = 0;
		for (n = 0; n < PAYLOAD_BYTES; n++)
			shadow_bytes[n] = 8'h00;
		cmd.valid = 1'b0;
		cmd.kind = KIND_LOAD;
		cmd.payload_data = '0;
		cmd.payload_length = '0;
		cmd.start_bit = '0;
		cmd.signal_bits = '0;
		cmd.big_endian = 1'b0;
		cmd.is_signed = 1'b0;
		cmd.insert_value = '0;
		res.ready = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_cmd(KIND_EXTRACT, '0, 0, 0, 8, 0, 1, 0);
		// empty payload grows to one byte on insert
		push_cmd(KIND_INSERT, '0, 0, 3, 4, 0, 0, 64'hF);
		push_cmd(KIND_LOAD, 64'h0123_4567_89AB_CDEF, 4'd15, 0, 0, 0, 0, 0);
		push_cmd(KIND_EXTRACT, '0, 0, 0, 64, 0, 0, 0);
		push_cmd(KIND_EXTRACT, '0, 0, 7, 64, 1, 1, 0);
		push_cmd(KIND_EXTRACT, '0, 0, 4, 12, 0, 1, 0);
		push_cmd(KIND_EXTRACT, '0, 0, 12, 127, 1, 0, 0);
		push_cmd(KIND_EXTRACT, '0, 0, 63, 0, 0, 1, 0);
		push_cmd(KIND_INSERT, '0, 0, 10, 0, 0, 0, -1);
		push_cmd(KIND_NOP, '1, 4'hF, 63, 127, 1, 1, -1);
		push_cmd(KIND_LOAD, '1, 0, 0, 0, 0, 0, 0);
		push_cmd(KIND_INSERT, '0, 0, 0, 0, 0, 0, 0);
		push_cmd(KIND_LOAD, 64'hFFFF_FFFF_FFAA_5501, 3, 0, 0, 0, 0, 0);
		// intel walk runs off the last byte
		push_cmd(KIND_INSERT, '0, 0, 20, 16, 0, 0, -1);
		// motorola walk crosses into the first byte and ends there
		push_cmd(KIND_INSERT, '0, 0, 0, 12, 1, 0, 64'hA5A);
		push_cmd(KIND_EXTRACT, '0, 0, 7, 8, 1, 1, 0);
		push_cmd(KIND_EXTRACT, '0, 0, 0, 24, 0, 1, 0);
		push_cmd(KIND_LOAD, '0, 8, 0, 0, 0, 0, 0);
		push_cmd(KIND_INSERT, '0, 0, 63, 64, 0, 0, 64'sh8000_0000_0000_0000);
		push_cmd(KIND_INSERT, '0, 0, 56, 64, 1, 0, 64'sh7FFF_FFFF_FFFF_FFFF);
		push_cmd(KIND_EXTRACT, '0, 0, 0, 64, 0, 1, 0);
		push_cmd(KIND_LOAD, '1, 8, 0, 0, 0, 0, 0);
		push_cmd(KIND_EXTRACT, '0, 0, 0, 1, 0, 1, 0);
		push_cmd(KIND_EXTRACT, '0, 0, 56, 64, 1, 1, 0);
		gen_len = 8;

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 49;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 49;
					// receiver stops for a long stretch so the input backs up
					hold_req = 1'b1;
				end
				default: begin
					send_idle_pct = 36;
					recv_stall_pct = 36;
				end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				it = random_item(gen_len);
				if (it.kind == KIND_LOAD)
					gen_len = (it.plen > 4'(PAYLOAD_BYTES)) ? PAYLOAD_BYTES : int'(it.plen);
				else if (it.kind == KIND_INSERT && gen_len == 0)
					gen_len = 1;
				cmd_items_q = {cmd_items_q, it};
				items_sent++;
			end
			// sender pauses until the block has drained
			while (items_taken != items_sent || frame_results_q.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
